@@ rtl/core/bgd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int unsigned TimerW   = 16;
  localparam int unsigned ClicksW  = 3;
  localparam int unsigned EventW   = 3;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [TimerW-1:0] DebounceReset  = 16'd20;
  localparam logic [TimerW-1:0] LongPressReset = 16'd800;
  localparam logic [TimerW-1:0] ClickGapReset  = 16'd400;

  localparam logic [TimerW-1:0]  TimerMax  = {TimerW{1'b1}};
  localparam logic [ClicksW-1:0] ClicksMax = {ClicksW{1'b1}};
  localparam logic [ClicksW-1:0] ClicksReportMax = 3'd3;

  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CLICK_GAP  = 2'd2;

  localparam logic [EventW-1:0] EV_NONE   = 3'd0;
  localparam logic [EventW-1:0] EV_LONG   = 3'd1;
  localparam logic [EventW-1:0] EV_SINGLE = 3'd2;
  localparam logic [EventW-1:0] EV_DOUBLE = 3'd3;
  localparam logic [EventW-1:0] EV_TRIPLE = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'b0001,
    PH_DEB_PRESS   = 4'b0010,
    PH_PRESSED     = 4'b0100,
    PH_DEB_RELEASE = 4'b1000
  } phase_e;

endpackage

@@ rtl/core/button_gesture_detector.sv @@
// ----------------------------------------------------------------------------
// button_gesture_detector
// Debounce, long press and single/double/triple click detection per tick.
// ----------------------------------------------------------------------------
// Each request is one tick carrying the raw pin level (0 pressed). The block
// returns exactly one result per request: a gesture event (0 none, 1 long
// press, 2..4 single to triple click) and the debounced pressed level. One
// request is taken every cycle unless a held result stalls the input; each request
// passes the input register, then the result register, and the per-tick
// phase and counter update sits between those two registers. Registers may be
// written only while no request is in flight; the port is always ready.
// ----------------------------------------------------------------------------
module button_gesture_detector import bgd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimerW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               raw_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [EventW-1:0]  gesture_event_o,
  output logic               debounced_pressed_o
);

  logic [TimerW-1:0]  debounce_q, long_press_q, click_gap_q;

  logic               s1_valid_q;
  logic               level_q;
  logic               advance;

  phase_e             phase_q, phase_d, phase_mid;
  logic [TimerW-1:0]  timer_q, timer_d, timer_mid, timer_dec, hold_q, hold_d, hold_inc;
  logic [ClicksW-1:0] clicks_q, clicks_d, clicks_mid;
  logic               long_q, long_d;
  logic               expire1, expire2;
  logic [EventW-1:0]  event_d;

  logic               out_valid_q;
  logic [EventW-1:0]  event_q;
  logic               pressed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
      click_gap_q  <= ClickGapReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        REG_LONG_PRESS: long_press_q <= cfg_data_i;
        REG_CLICK_GAP:  click_gap_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register and its handoff to the result register
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      level_q <= raw_level_i;
    end
  end

  // Phase machine, then click gap check on the updated state
  assign expire1   = (timer_q <= 16'd1);
  assign timer_dec = expire1 ? '0 : timer_q - 16'd1;
  assign hold_inc  = (hold_q == TimerMax) ? hold_q : hold_q + 16'd1;
  assign expire2   = (timer_mid <= 16'd1);

  always_comb begin
    phase_mid  = phase_q;
    timer_mid  = timer_q;
    hold_d     = hold_q;
    clicks_mid = clicks_q;
    long_d     = long_q;
    event_d    = EV_NONE;
    unique case (phase_q)
      PH_IDLE: begin
        if (!level_q) begin
          phase_mid = PH_DEB_PRESS;
          timer_mid = debounce_q;
        end
      end
      PH_DEB_PRESS: begin
        if (!level_q) begin
          timer_mid = timer_dec;
          if (expire1) begin
            phase_mid = PH_PRESSED;
            hold_d    = '0;
            long_d    = 1'b0;
          end
        end else begin
          phase_mid = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        hold_d = hold_inc;
        if (!long_q && (hold_inc >= long_press_q)) begin
          long_d  = 1'b1;
          event_d = EV_LONG;
        end
        if (level_q) begin
          phase_mid = PH_DEB_RELEASE;
          timer_mid = debounce_q;
        end
      end
      PH_DEB_RELEASE: begin
        if (level_q) begin
          timer_mid = timer_dec;
          if (expire1) begin
            phase_mid = PH_IDLE;
            if (!long_q) begin
              if (clicks_q != ClicksMax) clicks_mid = clicks_q + 3'd1;
              timer_mid = click_gap_q;
            end else begin
              clicks_mid = '0;
            end
          end
        end else begin
          phase_mid = PH_PRESSED;
        end
      end
      default: begin
        phase_mid = PH_IDLE;
      end
    endcase

    phase_d  = phase_mid;
    timer_d  = timer_mid;
    clicks_d = clicks_mid;
    if ((clicks_mid != '0) && (phase_mid == PH_IDLE)) begin
      timer_d = expire2 ? '0 : timer_mid - 16'd1;
      if (expire2) begin
        if (clicks_mid <= ClicksReportMax) event_d = clicks_mid + 3'd1;
        clicks_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      timer_q  <= '0;
      hold_q   <= '0;
      clicks_q <= '0;
      long_q   <= 1'b0;
    end else if (advance) begin
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      hold_q   <= hold_d;
      clicks_q <= clicks_d;
      long_q   <= long_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q   <= event_d;
      pressed_q <= (phase_d == PH_PRESSED) || (phase_d == PH_DEB_RELEASE);
    end
  end

  assign out_valid_o         = out_valid_q;
  assign gesture_event_o     = event_q;
  assign debounced_pressed_o = pressed_q;

  a_long_while_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && gesture_event_o == EV_LONG) |-> debounced_pressed_o)
    else $error("long press reported while not pressed");

  a_click_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (gesture_event_o == EV_SINGLE || gesture_event_o == EV_DOUBLE ||
                     gesture_event_o == EV_TRIPLE)) |-> !debounced_pressed_o)
    else $error("click reported while pressed");

  a_hold_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PRESSED && $past(phase_q) == PH_PRESSED) |-> (hold_q >= $past(hold_q)))
    else $error("hold time decreased during a press");

  a_long_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(long_q) |-> (phase_q == PH_PRESSED))
    else $error("long press flag cleared outside press entry");

  a_no_update_without_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(advance) |-> ($stable(phase_q) && $stable(timer_q) && $stable(clicks_q)))
    else $error("state changed without a request");

endmodule

@@ test/gesture_checker.sv @@
// ----------------------------------------------------------------------------
// Gesture checker
// Watches the register, tick and result channels of the button gesture
// detector. Runs its own tick-by-tick copy of the debounce and click machine
// on every accepted request and compares each result with the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gesture_checker import bgd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TimerW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               raw_level_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [EventW-1:0]  gesture_event_i,
  input  logic               debounced_pressed_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        result_count_o,
  output int unsigned        long_count_o,
  output int unsigned        single_count_o,
  output int unsigned        double_count_o,
  output int unsigned        triple_count_o
);

  typedef struct packed {
    logic [EventW-1:0] gesture;
    logic              pressed;
  } tick_result_t;

  logic [TimerW-1:0]  debounce_ticks;
  logic [TimerW-1:0]  long_ticks;
  logic [TimerW-1:0]  gap_ticks;
  phase_e             phase;
  logic [TimerW-1:0]  down_timer;
  logic [TimerW-1:0]  hold_time;
  logic [ClicksW-1:0] clicks;
  logic               long_seen;
  tick_result_t       expected_q[$];
  tick_result_t       want;

  function automatic logic timer_expired();
    if (down_timer <= 16'd1) begin
      down_timer = '0;
      return 1'b1;
    end
    down_timer = down_timer - 1'b1;
    return 1'b0;
  endfunction

  function automatic tick_result_t predict_tick(input logic released);
    tick_result_t res;
    res.gesture = EV_NONE;
    case (phase)
      PH_IDLE: begin
        if (!released) begin
          phase      = PH_DEB_PRESS;
          down_timer = debounce_ticks;
        end
      end
      PH_DEB_PRESS: begin
        if (released) begin
          phase = PH_IDLE;
        end else if (timer_expired()) begin
          phase     = PH_PRESSED;
          hold_time = '0;
          long_seen = 1'b0;
        end
      end
      PH_PRESSED: begin
        if (hold_time != TimerMax) hold_time = hold_time + 1'b1;
        if (!long_seen && hold_time >= long_ticks) begin
          long_seen   = 1'b1;
          res.gesture = EV_LONG;
        end
        if (released) begin
          phase      = PH_DEB_RELEASE;
          down_timer = debounce_ticks;
        end
      end
      default: begin
        if (!released) begin
          phase = PH_PRESSED;
        end else if (timer_expired()) begin
          phase = PH_IDLE;
          if (long_seen) begin
            clicks = '0;
          end else begin
            if (clicks != ClicksMax) clicks = clicks + 1'b1;
            down_timer = gap_ticks;
          end
        end
      end
    endcase
    // report pending clicks once the shared counter runs out in idle
    if (clicks != '0 && phase == PH_IDLE) begin
      if (timer_expired()) begin
        case (clicks)
          3'd1:    res.gesture = EV_SINGLE;
          3'd2:    res.gesture = EV_DOUBLE;
          3'd3:    res.gesture = EV_TRIPLE;
          default: ;
        endcase
        clicks = '0;
      end
    end
    res.pressed = (phase == PH_PRESSED) || (phase == PH_DEB_RELEASE);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks = DebounceReset;
      long_ticks     = LongPressReset;
      gap_ticks      = ClickGapReset;
      phase          = PH_IDLE;
      down_timer     = '0;
      hold_time      = '0;
      clicks         = '0;
      long_seen      = 1'b0;
      expected_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      result_count_o = 0;
      long_count_o   = 0;
      single_count_o = 0;
      double_count_o = 0;
      triple_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DEBOUNCE:   debounce_ticks = cfg_data_i;
          REG_LONG_PRESS: long_ticks     = cfg_data_i;
          REG_CLICK_GAP:  gap_ticks      = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: gesture_event %0d, debounced_pressed %0d",
                 gesture_event_i, debounced_pressed_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          result_count_o = result_count_o + 1;
          if (gesture_event_i !== want.gesture) begin
            $error("gesture_event: expected %0d, actual %0d", want.gesture, gesture_event_i);
            fail_count_o = fail_count_o + 1;
          end
          if (debounced_pressed_i !== want.pressed) begin
            $error("debounced_pressed: expected %0d, actual %0d",
                   want.pressed, debounced_pressed_i);
            fail_count_o = fail_count_o + 1;
          end
          case (want.gesture)
            EV_LONG:   long_count_o   = long_count_o + 1;
            EV_SINGLE: single_count_o = single_count_o + 1;
            EV_DOUBLE: double_count_o = double_count_o + 1;
            EV_TRIPLE: triple_count_o = triple_count_o + 1;
            default: ;
          endcase
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_tick(raw_level_i));
      pending_o = expected_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Button gesture detector testbench
// Drives raw button ticks and register writes into the detector: reset
// defaults, zero timers, multi-click and bounce sequences, full-scale
// registers, a steady hold well past the long threshold, then random gestures
// under random small timer settings. The checker beside the block predicts
// and compares; this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import bgd_pkg::*;

  localparam int unsigned         CycleLimit = 1_000_000;
  localparam int unsigned         LongHold   = 300;
  localparam logic [CfgIdxW-1:0]  RegUnused  = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TimerW-1:0]  cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               raw_level;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [EventW-1:0]  gesture_event;
  logic               debounced_pressed;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        result_count;
  int unsigned        long_count;
  int unsigned        single_count;
  int unsigned        double_count;
  int unsigned        triple_count;

  int unsigned        cycle_count = 0;
  int unsigned        sent        = 0;
  int unsigned        settings    = 0;
  int unsigned        burst_left  = 0;
  bit                 steady      = 1'b0;
  int unsigned        cur_deb;
  int unsigned        cur_long;
  int unsigned        cur_gap;
  logic [7:0]         stall_age   = '0;
  logic [1:0]         stall_mode  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_gesture_detector uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .raw_level_i         (raw_level),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .gesture_event_o     (gesture_event),
    .debounced_pressed_o (debounced_pressed)
  );

  gesture_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .raw_level_i         (raw_level),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .gesture_event_i     (gesture_event),
    .debounced_pressed_i (debounced_pressed),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .result_count_o      (result_count),
    .long_count_o        (long_count),
    .single_count_o      (single_count),
    .double_count_o      (double_count),
    .triple_count_o      (triple_count)
  );

  // receiver: pick a new stall pattern each time the 8-bit stall_age counter wraps
  always @(negedge clk) begin
    stall_age <= stall_age + 1'b1;
    if (stall_age == '0) stall_mode <= 2'($urandom_range(0, 2));
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= (stall_age[1:0] != 2'd0);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_tick(input logic lvl);
    if (burst_left == 0) begin
      if (!steady) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid  <= 1'b1;
    raw_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left = burst_left - 1;
    sent       = sent + 1;
  endtask

  task automatic hold_level(input logic lvl, input int unsigned n);
    repeat (n) send_tick(lvl);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimerW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned deb, input int unsigned lng,
                           input int unsigned gap);
    wait_drain();
    write_reg(REG_DEBOUNCE, TimerW'(deb));
    write_reg(REG_LONG_PRESS, TimerW'(lng));
    write_reg(REG_CLICK_GAP, TimerW'(gap));
    write_reg(RegUnused, TimerW'($urandom));
    cfg_valid <= 1'b0;
    cur_deb  = deb;
    cur_long = lng;
    cur_gap  = gap;
    settings = settings + 1;
  endtask

  task automatic click();
    hold_level(1'b0, 2);
    hold_level(1'b1, 2);
  endtask

  // mostly press/release pairs sized around the thresholds, some noise
  task automatic run_gestures(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        hold_level(1'b0, $urandom_range(1, cur_deb + cur_long + cur_long / 2 + 3));
        hold_level(1'b1, $urandom_range(1, cur_deb + cur_gap + 3));
      end
      if ($urandom_range(0, 39) == 0) wait_drain();
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    raw_level = 1'b1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: press and release just past the default debounce
    hold_level(1'b0, 22);
    hold_level(1'b1, 22);

    // zero timers and zero long threshold
    configure(0, 0, 0);
    hold_level(1'b0, 3);
    hold_level(1'b1, 2);

    // four clicks, then a bounce while they are pending
    configure(1, 3, 3);
    repeat (4) click();
    send_tick(1'b0);
    hold_level(1'b1, 2);

    // full-scale registers
    configure(TimerMax, TimerMax, TimerMax);
    repeat (40) send_tick(1'($urandom_range(0, 1)));

    // steady hold well past the long threshold, then release
    configure(1, 250, TimerMax);
    steady = 1'b1;
    hold_level(1'b1, 3);
    hold_level(1'b0, LongHold);
    hold_level(1'b1, 4);
    steady = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      configure($urandom_range(0, 3), $urandom_range(0, 30), $urandom_range(0, 10));
      run_gestures(100);
    end

    wait_drain();
    repeat (4) @(negedge clk);

    $display("Sent %0d ticks under %0d register settings, zero and full-scale timers included.",
             sent, settings);
    $display("Checked %0d results: %0d long presses, %0d single, %0d double, %0d triple clicks.",
             result_count, long_count, single_count, double_count, triple_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ button_gesture_detector.f @@
rtl/core/bgd_pkg.sv
rtl/core/button_gesture_detector.sv
test/gesture_checker.sv
test/tb_top.sv
